// ----- design/slps_pkg.sv -----
// Shared types, codes and constants for the status LED pattern sequencer.
// No dependencies; every other design file imports this package.
package slps_pkg;

  localparam int unsigned DUTY_W     = 13;
  localparam int unsigned MS_W       = 10;
  localparam int unsigned ELAPSED_W  = 16;
  localparam int unsigned BLINK_W    = 11;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // LED pattern codes. Code 7 has no meaning and is never stored.
  typedef enum logic [2:0] {
    PAT_OFF    = 3'd0,
    PAT_SINGLE = 3'd1,
    PAT_DOUBLE = 3'd2,
    PAT_TRIPLE = 3'd3,
    PAT_BLINK  = 3'd4,
    PAT_SOLID  = 3'd5,
    PAT_FADE   = 3'd6
  } pattern_e;

  // Kind of an input request.
  typedef enum logic {
    KIND_TICK    = 1'b0,
    KIND_REQUEST = 1'b1
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_DUTY        = 3'd0,
    CFG_SINGLE_ON_MS     = 3'd1,
    CFG_SINGLE_OFF_MS    = 3'd2,
    CFG_DOUBLE_PHASE_MS  = 3'd3,
    CFG_TRIPLE_PHASE_MS  = 3'd4,
    CFG_BLINK_HALF_MS    = 3'd5,
    CFG_FADE_INTERVAL_MS = 3'd6,
    CFG_FADE_STEP        = 3'd7
  } cfg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [DUTY_W-1:0] RST_FULL_DUTY        = 13'd8191;
  localparam logic [MS_W-1:0]   RST_SINGLE_ON_MS     = 10'd80;
  localparam logic [MS_W-1:0]   RST_SINGLE_OFF_MS    = 10'd120;
  localparam logic [MS_W-1:0]   RST_DOUBLE_PHASE_MS  = 10'd60;
  localparam logic [MS_W-1:0]   RST_TRIPLE_PHASE_MS  = 10'd50;
  localparam logic [MS_W-1:0]   RST_BLINK_HALF_MS    = 10'd100;
  localparam logic [MS_W-1:0]   RST_FADE_INTERVAL_MS = 10'd20;
  localparam logic [MS_W-1:0]   RST_FADE_STEP        = 10'd20;

  typedef struct packed {
    logic [DUTY_W-1:0] full_duty;
    logic [MS_W-1:0]   single_on_ms;
    logic [MS_W-1:0]   single_off_ms;
    logic [MS_W-1:0]   double_phase_ms;
    logic [MS_W-1:0]   triple_phase_ms;
    logic [MS_W-1:0]   blink_half_ms;
    logic [MS_W-1:0]   fade_interval_ms;
    logic [MS_W-1:0]   fade_step;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] requested_pattern;
    logic       pairing_active;
    logic       ota_active;
  } item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [2:0]        active_pattern;
  } result_t;

endpackage

// ----- design/slps_if.sv -----
// Handshake channel interfaces of the status LED pattern sequencer.
// Depends on slps_pkg for the payload types and widths.
interface slps_item_if;
  import slps_pkg::*;
  logic  valid;
  logic  ready;
  item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface slps_result_if;
  import slps_pkg::*;
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface slps_cfg_if;
  import slps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/slps_cfg_regs.sv -----
// Configuration register file of the status LED pattern sequencer.
// Depends on slps_pkg for the register indexes, widths and reset values.
module slps_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_en_i,
  input  logic [slps_pkg::CFG_IDX_W-1:0]  wr_idx_i,
  input  logic [slps_pkg::CFG_DATA_W-1:0] wr_data_i,
  output slps_pkg::cfg_t                  cfg_o
);
  import slps_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_idx_e'(wr_idx_i))
        CFG_FULL_DUTY:        cfg_d.full_duty        = wr_data_i[DUTY_W-1:0];
        CFG_SINGLE_ON_MS:     cfg_d.single_on_ms     = wr_data_i[MS_W-1:0];
        CFG_SINGLE_OFF_MS:    cfg_d.single_off_ms    = wr_data_i[MS_W-1:0];
        CFG_DOUBLE_PHASE_MS:  cfg_d.double_phase_ms  = wr_data_i[MS_W-1:0];
        CFG_TRIPLE_PHASE_MS:  cfg_d.triple_phase_ms  = wr_data_i[MS_W-1:0];
        CFG_BLINK_HALF_MS:    cfg_d.blink_half_ms    = wr_data_i[MS_W-1:0];
        CFG_FADE_INTERVAL_MS: cfg_d.fade_interval_ms = wr_data_i[MS_W-1:0];
        CFG_FADE_STEP:        cfg_d.fade_step        = wr_data_i[MS_W-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_duty        <= RST_FULL_DUTY;
      cfg_q.single_on_ms     <= RST_SINGLE_ON_MS;
      cfg_q.single_off_ms    <= RST_SINGLE_OFF_MS;
      cfg_q.double_phase_ms  <= RST_DOUBLE_PHASE_MS;
      cfg_q.triple_phase_ms  <= RST_TRIPLE_PHASE_MS;
      cfg_q.blink_half_ms    <= RST_BLINK_HALF_MS;
      cfg_q.fade_interval_ms <= RST_FADE_INTERVAL_MS;
      cfg_q.fade_step        <= RST_FADE_STEP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/slps_engine.sv -----
// Pattern state registers and the single-pass update of one request.
// Depends on slps_pkg for pattern codes, types and widths.
module slps_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  slps_pkg::item_t             item_i,
  input  slps_pkg::cfg_t              cfg_i,
  output slps_pkg::result_t           result_o
);
  import slps_pkg::*;

  localparam logic [STEP_W-1:0] DOUBLE_STEPS     = STEP_W'(4);
  localparam logic [STEP_W-1:0] TRIPLE_LAST_STEP = STEP_W'(5);

  pattern_e             pat_q, pat_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [ELAPSED_W-1:0] pe_q, pe_d;
  logic [BLINK_W-1:0]   bc_q, bc_d;
  logic [ELAPSED_W-1:0] fe_q, fe_d;
  logic [DUTY_W-1:0]    lvl_q, lvl_d;
  logic                 rise_q, rise_d;
  logic [DUTY_W-1:0]    duty_q, duty_d;

  logic [MS_W-1:0]      half;
  logic [BLINK_W-1:0]   bc_inc;
  logic [DUTY_W:0]      rise_sum;
  logic [DUTY_W-1:0]    step_ext;
  logic [DUTY_W-1:0]    full_or_off;

  always_comb begin
    pat_d  = pat_q;
    step_d = step_q;
    pe_d   = pe_q;
    bc_d   = bc_q;
    fe_d   = fe_q;
    lvl_d  = lvl_q;
    rise_d = rise_q;
    duty_d = duty_q;

    // A zero half period behaves as one millisecond.
    half        = (cfg_i.blink_half_ms == '0) ? MS_W'(1) : cfg_i.blink_half_ms;
    bc_inc      = bc_q + BLINK_W'(1);
    step_ext    = DUTY_W'(cfg_i.fade_step);
    rise_sum    = {1'b0, lvl_q} + {1'b0, step_ext};
    full_or_off = step_q[0] ? '0 : cfg_i.full_duty;

    if (kind_e'(item_i.kind) == KIND_REQUEST) begin
      if (item_i.pairing_active) begin
        pat_d = PAT_FADE;
      end else if (item_i.ota_active) begin
        pat_d = PAT_BLINK;
      end else begin
        pat_d  = (item_i.requested_pattern > PAT_FADE) ? PAT_OFF
                                                       : pattern_e'(item_i.requested_pattern);
        step_d = '0;
        pe_d   = '0;
      end
    end else begin
      if (pe_q != '1) begin
        pe_d = pe_q + ELAPSED_W'(1);
      end
      if (fe_q != '1) begin
        fe_d = fe_q + ELAPSED_W'(1);
      end
      bc_d = (bc_inc >= {half, 1'b0}) ? '0 : bc_inc;

      if (item_i.pairing_active) begin
        if (pat_q != PAT_FADE) begin
          pat_d  = PAT_FADE;
          step_d = '0;
          pe_d   = '0;
        end
      end else if (item_i.ota_active) begin
        if (pat_q != PAT_BLINK) begin
          pat_d  = PAT_BLINK;
          step_d = '0;
          pe_d   = '0;
        end
      end

      case (pat_d)
        PAT_SINGLE: begin
          if (step_d == '0) begin
            duty_d = cfg_i.full_duty;
            if (pe_d > ELAPSED_W'(cfg_i.single_on_ms)) begin
              step_d = STEP_W'(1);
              pe_d   = '0;
            end
          end else if (step_d == STEP_W'(1)) begin
            duty_d = '0;
            if (pe_d > ELAPSED_W'(cfg_i.single_off_ms)) begin
              pat_d = PAT_OFF;
            end
          end
        end
        PAT_DOUBLE: begin
          if (step_d < DOUBLE_STEPS) begin
            duty_d = step_d[0] ? '0 : cfg_i.full_duty;
            if (pe_d > ELAPSED_W'(cfg_i.double_phase_ms)) begin
              step_d = step_d + STEP_W'(1);
              pe_d   = '0;
            end
          end else begin
            pat_d = PAT_OFF;
          end
        end
        PAT_TRIPLE: begin
          duty_d = step_d[0] ? '0 : cfg_i.full_duty;
          if (pe_d > ELAPSED_W'(cfg_i.triple_phase_ms)) begin
            step_d = step_d + STEP_W'(1);
            pe_d   = '0;
          end
          if (step_d > TRIPLE_LAST_STEP) begin
            pat_d = PAT_OFF;
          end
        end
        PAT_BLINK: begin
          duty_d = (bc_d >= BLINK_W'(half)) ? cfg_i.full_duty : '0;
        end
        PAT_SOLID: begin
          duty_d = cfg_i.full_duty;
        end
        PAT_FADE: begin
          if (fe_d > ELAPSED_W'(cfg_i.fade_interval_ms)) begin
            if (rise_q) begin
              if (rise_sum >= {1'b0, cfg_i.full_duty}) begin
                lvl_d  = cfg_i.full_duty;
                rise_d = 1'b0;
              end else begin
                lvl_d = rise_sum[DUTY_W-1:0];
              end
            end else begin
              // Falling clamps at zero rather than wrapping.
              if (lvl_q <= step_ext) begin
                lvl_d  = '0;
                rise_d = 1'b1;
              end else begin
                lvl_d = lvl_q - step_ext;
              end
            end
            duty_d = lvl_d;
            fe_d   = '0;
          end
        end
        default: begin
          duty_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= PAT_OFF;
      step_q <= '0;
      pe_q   <= '0;
      bc_q   <= '0;
      fe_q   <= '0;
      lvl_q  <= '0;
      rise_q <= 1'b1;
      duty_q <= '0;
    end else if (en_i) begin
      pat_q  <= pat_d;
      step_q <= step_d;
      pe_q   <= pe_d;
      bc_q   <= bc_d;
      fe_q   <= fe_d;
      lvl_q  <= lvl_d;
      rise_q <= rise_d;
      duty_q <= duty_d;
    end
  end

  assign result_o.duty           = duty_d;
  assign result_o.active_pattern = pat_d;

  // full_or_off is the duty a flash pattern drives for the current step when no
  // override moved the step; it must agree with what the update picks.
  logic flash_unmoved;
  assign flash_unmoved = en_i && (kind_e'(item_i.kind) == KIND_TICK) &&
                         !item_i.pairing_active && !item_i.ota_active &&
                         (pat_q == PAT_TRIPLE);

  a_triple_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flash_unmoved |-> (duty_d == full_or_off))
    else $error("triple flash duty does not follow the step parity");

  a_request_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (kind_e'(item_i.kind) == KIND_REQUEST) && !item_i.pairing_active &&
    !item_i.ota_active |=> (pe_q == '0) && (step_q == '0))
    else $error("plain request did not restart step and elapsed time");

  a_fade_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (pat_d == PAT_FADE) && !rise_q && (lvl_q <= step_ext) &&
    (fe_d == '0) && (kind_e'(item_i.kind) == KIND_TICK) |=> (lvl_q == '0) && rise_q)
    else $error("falling fade did not clamp at zero");

endmodule

// ----- design/status_led_pattern_sequencer.sv -----
// Status LED pattern sequencer: one input request to one result.
// The request channel feeds an input register, slps_engine computes the update
// and the result register holds it for the receiver. Configuration comes through
// slps_cfg_regs. Channel interfaces are in slps_if.sv; shared types in slps_pkg.
//
// Channels: item_i carries requests (a one-millisecond tick or a pattern
// request with the pairing and OTA override levels). result_o returns, for
// every request, the current PWM duty and the pattern in force. cfg_i writes
// the eight configuration registers by index; it is always ready and should
// only be written while no request is in flight.
//
// Flow: a request taken into the input register moves through the update into the
// result register as soon as that register is free. Throughput is one request per
// cycle while the receiver does not stall; the update is a single pass of
// counters and compares, so each request sees the state left by the one before.
//
// Reset clears all pattern state to pattern off, duty zero and a rising fade,
// and loads the configuration reset values. When the receiver stalls, the
// result register holds its request and the input register fills behind it;
// item_i.ready drops only when both are full and result_o.ready is low.
module status_led_pattern_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  slps_cfg_if.sink       cfg_i,
  slps_item_if.sink      item_i,
  slps_result_if.source  result_o
);
  import slps_pkg::*;

  cfg_t    cfg;
  item_t   in_q;
  logic    in_vld_q, in_vld_d;
  result_t res_q;
  logic    res_vld_q, res_vld_d;
  result_t res_next;
  logic    out_free;
  logic    in_take;
  logic    step_en;

  // Configuration writes land at once; the port never stalls.
  assign cfg_i.ready = 1'b1;

  slps_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  // The result register frees up when empty or when its request is taken.
  assign out_free     = !res_vld_q || result_o.ready;
  assign step_en      = in_vld_q && out_free;
  assign item_i.ready = !in_vld_q || out_free;
  assign in_take      = item_i.valid && item_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (step_en) begin
      in_vld_d = 1'b0;
    end
    res_vld_d = res_vld_q;
    if (step_en) begin
      res_vld_d = 1'b1;
    end else if (result_o.ready) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= item_i.payload;
    end
    if (step_en) begin
      res_q <= res_next;
    end
  end

  slps_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (step_en),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (res_next)
  );

  assign result_o.valid   = res_vld_q;
  assign result_o.payload = res_q;

  a_step_fills_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en |=> res_vld_q)
    else $error("processed request did not reach the result register");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_i.ready |-> in_vld_q && res_vld_q && !result_o.ready)
    else $error("input stalled while the pipeline had room");

  a_pairing_forces_fade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en && in_q.pairing_active |=> res_q.active_pattern == PAT_FADE)
    else $error("pairing level did not force the fade pattern");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for status_led_pattern_sequencer (design/slps_pkg.sv,
// design/slps_if.sv). An in-bench model predicts duty and active pattern per
// request; results are checked in order while both channels idle and stall.
module tb_top;
  import slps_pkg::*;

  // Pattern code 7 has no meaning; a plain request for it must store pattern off.
  localparam logic [2:0] PAT_UNUSED = 3'd7;

  logic clk_i;
  logic rst_ni;

  slps_item_if   item_if ();
  slps_result_if result_if ();
  slps_cfg_if    cfg_if ();

  status_led_pattern_sequencer u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .item_i   (item_if),
    .result_o (result_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // A stuck handshake or a lost result ends the run here.
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // LED model: configuration and pattern state as the block should hold them.
  // ---------------------------------------------------------------------------
  cfg_t                  led_cfg;
  pattern_e              cur_pat;
  logic [STEP_W-1:0]     cur_step;
  logic [ELAPSED_W-1:0]  pat_ms;
  logic [ELAPSED_W-1:0]  fade_ms;
  int unsigned           blink_cnt;
  logic [DUTY_W-1:0]     fade_lvl;
  logic                  fade_up;
  logic [DUTY_W-1:0]     duty_q;

  // Expected duty and pattern, one per accepted request, oldest first.
  result_t led_status_q[$];
  int      mismatch_cnt = 0;

  // Sender burst shaping.
  int burst_left = 0;
  int gap_max    = 3;

  function automatic cfg_t default_cfg();
    cfg_t c;
    c.full_duty        = RST_FULL_DUTY;
    c.single_on_ms     = RST_SINGLE_ON_MS;
    c.single_off_ms    = RST_SINGLE_OFF_MS;
    c.double_phase_ms  = RST_DOUBLE_PHASE_MS;
    c.triple_phase_ms  = RST_TRIPLE_PHASE_MS;
    c.blink_half_ms    = RST_BLINK_HALF_MS;
    c.fade_interval_ms = RST_FADE_INTERVAL_MS;
    c.fade_step        = RST_FADE_STEP;
    return c;
  endfunction

  // Random timing with every millisecond threshold in 0..ms_max.
  function automatic cfg_t random_cfg(int ms_max);
    cfg_t c;
    c.full_duty        = DUTY_W'($urandom_range(0, 8191));
    c.single_on_ms     = MS_W'($urandom_range(0, ms_max));
    c.single_off_ms    = MS_W'($urandom_range(0, ms_max));
    c.double_phase_ms  = MS_W'($urandom_range(0, ms_max));
    c.triple_phase_ms  = MS_W'($urandom_range(0, ms_max));
    c.blink_half_ms    = MS_W'($urandom_range(0, ms_max));
    c.fade_interval_ms = MS_W'($urandom_range(0, ms_max));
    c.fade_step        = MS_W'($urandom_range(1, 1023));
    return c;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] cfg_word(cfg_t c, cfg_idx_e idx);
    case (idx)
      CFG_FULL_DUTY:        return CFG_DATA_W'(c.full_duty);
      CFG_SINGLE_ON_MS:     return CFG_DATA_W'(c.single_on_ms);
      CFG_SINGLE_OFF_MS:    return CFG_DATA_W'(c.single_off_ms);
      CFG_DOUBLE_PHASE_MS:  return CFG_DATA_W'(c.double_phase_ms);
      CFG_TRIPLE_PHASE_MS:  return CFG_DATA_W'(c.triple_phase_ms);
      CFG_BLINK_HALF_MS:    return CFG_DATA_W'(c.blink_half_ms);
      CFG_FADE_INTERVAL_MS: return CFG_DATA_W'(c.fade_interval_ms);
      default:              return CFG_DATA_W'(c.fade_step);
    endcase
  endfunction

  function automatic item_t make_item(kind_e k, logic [2:0] pat, logic pairing, logic ota);
    item_t it;
    it.kind              = k;
    it.requested_pattern = pat;
    it.pairing_active    = pairing;
    it.ota_active        = ota;
    return it;
  endfunction

  function automatic logic rare_level();
    return ($urandom_range(0, 99) < 6);
  endfunction

  task automatic restart_pattern(input pattern_e p);
    cur_pat  = p;
    cur_step = '0;
    pat_ms   = '0;
  endtask

  task automatic next_step();
    cur_step = cur_step + 1'b1;
    pat_ms   = '0;
  endtask

  // One request through the model: a pattern request or a one-millisecond tick.
  task automatic led_update(input item_t it, output result_t r);
    int unsigned half;
    int unsigned lvl;
    if (it.kind == KIND_REQUEST) begin
      // Overrides only retag the pattern; the step and elapsed time survive.
      if (it.pairing_active) begin
        cur_pat = PAT_FADE;
      end else if (it.ota_active) begin
        cur_pat = PAT_BLINK;
      end else if (it.requested_pattern > PAT_FADE) begin
        restart_pattern(PAT_OFF);
      end else begin
        restart_pattern(pattern_e'(it.requested_pattern));
      end
    end else begin
      // A zero half period behaves as one millisecond.
      half = (led_cfg.blink_half_ms == '0) ? 1 : led_cfg.blink_half_ms;
      if (pat_ms != '1) pat_ms = pat_ms + 1'b1;
      if (fade_ms != '1) fade_ms = fade_ms + 1'b1;
      blink_cnt++;
      if (blink_cnt >= 2 * half) blink_cnt = 0;

      if (it.pairing_active) begin
        if (cur_pat != PAT_FADE) restart_pattern(PAT_FADE);
      end else if (it.ota_active) begin
        if (cur_pat != PAT_BLINK) restart_pattern(PAT_BLINK);
      end

      case (cur_pat)
        PAT_SINGLE: begin
          // A step past the trailing off phase leaves everything alone.
          if (cur_step == 0) begin
            duty_q = led_cfg.full_duty;
            if (pat_ms > led_cfg.single_on_ms) next_step();
          end else if (cur_step == 1) begin
            duty_q = '0;
            if (pat_ms > led_cfg.single_off_ms) cur_pat = PAT_OFF;
          end
        end
        PAT_DOUBLE: begin
          if (cur_step < 4) begin
            duty_q = cur_step[0] ? '0 : led_cfg.full_duty;
            if (pat_ms > led_cfg.double_phase_ms) next_step();
          end else begin
            cur_pat = PAT_OFF;
          end
        end
        PAT_TRIPLE: begin
          duty_q = cur_step[0] ? '0 : led_cfg.full_duty;
          if (pat_ms > led_cfg.triple_phase_ms) next_step();
          if (cur_step > 5) cur_pat = PAT_OFF;
        end
        PAT_BLINK: begin
          duty_q = (blink_cnt >= half) ? led_cfg.full_duty : '0;
        end
        PAT_SOLID: begin
          duty_q = led_cfg.full_duty;
        end
        PAT_FADE: begin
          if (fade_ms > led_cfg.fade_interval_ms) begin
            if (fade_up) begin
              // A level left above a lowered full duty clamps here too.
              lvl = fade_lvl + led_cfg.fade_step;
              if (lvl >= led_cfg.full_duty) begin
                lvl     = led_cfg.full_duty;
                fade_up = 1'b0;
              end
              fade_lvl = DUTY_W'(lvl);
            end else if (fade_lvl <= led_cfg.fade_step) begin
              fade_lvl = '0;
              fade_up  = 1'b1;
            end else begin
              fade_lvl = fade_lvl - led_cfg.fade_step;
            end
            duty_q  = fade_lvl;
            fade_ms = '0;
          end
        end
        default: begin
          duty_q = '0;
        end
      endcase
    end
    r.duty           = duty_q;
    r.active_pattern = cur_pat;
  endtask

  // ---------------------------------------------------------------------------
  // Channel drivers.
  // ---------------------------------------------------------------------------

  // Sends one request and records its expected result once it is accepted.
  // Requests go out in bursts; between bursts valid drops for a random gap.
  task automatic send_led_req(input item_t it);
    result_t r;
    int      gap;
    if (burst_left == 0) begin
      if (gap_max == 0) begin
        gap = 0;
      end else if ($urandom_range(0, 7) == 0) begin
        gap = $urandom_range(0, 4 * gap_max);
      end else begin
        gap = $urandom_range(0, gap_max);
      end
      if (gap > 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    item_if.valid   <= 1'b1;
    item_if.payload <= it;
    do @(posedge clk_i); while (!item_if.ready);
    led_update(it, r);
    led_status_q.push_back(r);
    burst_left--;
  endtask

  // Stops sending and waits until every expected result has come back,
  // then lets the two-stage pipeline settle before returning.
  task automatic drain_led();
    item_if.valid <= 1'b0;
    while (led_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all eight registers back to back; only called while idle.
  task automatic apply_settings(input cfg_t c);
    cfg_if.valid <= 1'b1;
    for (int i = CFG_FULL_DUTY; i <= CFG_FADE_STEP; i++) begin
      cfg_if.index <= cfg_idx_e'(i);
      cfg_if.data  <= cfg_word(c, cfg_idx_e'(i));
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
    led_cfg = c;
  endtask

  // Receiver: switches between always ready, light and heavy random stalls,
  // and a periodic stall, each held for a random stretch.
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 150);
      end
      left--;
      case (mode)
        0:       result_if.ready <= 1'b1;
        1:       result_if.ready <= ($urandom_range(0, 3) != 0);
        2:       result_if.ready <= ($urandom_range(0, 1) != 0);
        default: result_if.ready <= ((left % 8) < 2);
      endcase
    end
  end

  task automatic note_mismatch(input string what, input int unsigned want, input int unsigned got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("mismatch at %0t: %s expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  // Every accepted result is compared field by field with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (result_if.valid && result_if.ready) begin
      if (led_status_q.size() == 0) begin
        note_mismatch("unexpected result, duty", 0, result_if.payload.duty);
      end else begin
        want = led_status_q.pop_front();
        if (result_if.payload.duty !== want.duty) begin
          note_mismatch("duty", want.duty, result_if.payload.duty);
        end
        if (result_if.payload.active_pattern !== want.active_pattern) begin
          note_mismatch("active_pattern", want.active_pattern,
                        result_if.payload.active_pattern);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Random phase: mostly a pattern request followed by a run of ticks long
  // enough to walk the pattern, with occasional override levels; the rest
  // is fully random requests. The last run is cut to end at n_items.
  task automatic run_led_phase(input cfg_t c, input int n_items, input int max_run,
                               input int gap_limit);
    int sent;
    int run;
    drain_led();
    apply_settings(c);
    gap_max = gap_limit;
    sent    = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        send_led_req(make_item(KIND_REQUEST, 3'($urandom_range(0, 7)), rare_level(),
                               rare_level()));
        sent++;
        run = $urandom_range(1, max_run);
        if (run > n_items - sent) run = n_items - sent;
        repeat (run) begin
          send_led_req(make_item(KIND_TICK, 3'($urandom_range(0, 7)), rare_level(),
                                 rare_level()));
          sent++;
        end
      end else begin
        send_led_req(make_item(kind_e'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        sent++;
      end
    end
  endtask

  // Every pattern, the unused code and the overrides on short timing.
  task automatic test_directed_patterns();
    cfg_t c;
    c                  = default_cfg();
    c.single_on_ms     = 1;
    c.single_off_ms    = 0;
    c.double_phase_ms  = 0;
    c.triple_phase_ms  = 0;
    c.blink_half_ms    = 0;
    c.fade_interval_ms = 0;
    c.fade_step        = 1023;
    apply_settings(c);
    send_led_req(make_item(KIND_REQUEST, PAT_UNUSED, 1'b0, 1'b0));
    send_led_req(make_item(KIND_REQUEST, PAT_SINGLE, 1'b0, 1'b0));
    repeat (4) send_led_req(make_item(KIND_TICK, PAT_OFF, 1'b0, 1'b0));
    send_led_req(make_item(KIND_REQUEST, PAT_DOUBLE, 1'b0, 1'b0));
    repeat (5) send_led_req(make_item(KIND_TICK, PAT_OFF, 1'b0, 1'b0));
    send_led_req(make_item(KIND_REQUEST, PAT_TRIPLE, 1'b0, 1'b0));
    repeat (7) send_led_req(make_item(KIND_TICK, PAT_OFF, 1'b0, 1'b0));
    send_led_req(make_item(KIND_REQUEST, PAT_BLINK, 1'b0, 1'b0));
    repeat (2) send_led_req(make_item(KIND_TICK, PAT_OFF, 1'b0, 1'b0));
    send_led_req(make_item(KIND_REQUEST, PAT_SOLID, 1'b0, 1'b0));
    send_led_req(make_item(KIND_TICK, PAT_UNUSED, 1'b0, 1'b0));
    // Override levels on both kinds of request.
    send_led_req(make_item(KIND_REQUEST, PAT_OFF, 1'b1, 1'b0));
    send_led_req(make_item(KIND_TICK, PAT_OFF, 1'b1, 1'b0));
    send_led_req(make_item(KIND_TICK, PAT_OFF, 1'b0, 1'b1));
    send_led_req(make_item(KIND_TICK, PAT_OFF, 1'b1, 1'b1));
    send_led_req(make_item(KIND_REQUEST, PAT_SOLID, 1'b0, 1'b1));
    send_led_req(make_item(KIND_REQUEST, PAT_OFF, 1'b0, 1'b0));
    send_led_req(make_item(KIND_TICK, PAT_OFF, 1'b0, 1'b0));
  endtask

  // Drives the fade high, then lowers full duty under it while falling and
  // while rising, so the level sits above full in both directions.
  task automatic test_fade_above_full();
    cfg_t c;
    c                  = default_cfg();
    c.fade_interval_ms = 0;
    c.fade_step        = 1023;
    drain_led();
    apply_settings(c);
    send_led_req(make_item(KIND_REQUEST, PAT_FADE, 1'b0, 1'b0));
    repeat (12) send_led_req(make_item(KIND_TICK, PAT_OFF, 1'b0, 1'b0));
    c.full_duty = 1500;
    drain_led();
    apply_settings(c);
    repeat (6) send_led_req(make_item(KIND_TICK, PAT_OFF, 1'b0, 1'b0));
    c.full_duty = 8191;
    drain_led();
    apply_settings(c);
    repeat (5) send_led_req(make_item(KIND_TICK, PAT_OFF, 1'b0, 1'b0));
    c.full_duty = 1500;
    drain_led();
    apply_settings(c);
    repeat (4) send_led_req(make_item(KIND_TICK, PAT_OFF, 1'b0, 1'b0));
  endtask

  task automatic test_default_timing();
    run_led_phase(default_cfg(), 150, 260, 3);
  endtask

  task automatic test_short_timing();
    run_led_phase(random_cfg(8), 180, 40, 4);
  endtask

  // Smallest settings, including a zero half period and zero full duty.
  task automatic test_low_extremes();
    cfg_t c;
    c                  = random_cfg(0);
    c.full_duty        = 0;
    c.fade_step        = 1;
    run_led_phase(c, 60, 12, 2);
  endtask

  // Largest settings, sent with no gaps between requests.
  task automatic test_high_extremes();
    cfg_t c;
    c.full_duty        = 8191;
    c.single_on_ms     = 1023;
    c.single_off_ms    = 1023;
    c.double_phase_ms  = 1023;
    c.triple_phase_ms  = 1023;
    c.blink_half_ms    = 1023;
    c.fade_interval_ms = 1023;
    c.fade_step        = 1023;
    run_led_phase(c, 60, 40, 0);
  endtask

  task automatic test_random_settings();
    repeat (3) run_led_phase(random_cfg(20), 50, 60, 5);
  endtask

  initial begin
    rst_ni          <= 1'b0;
    item_if.valid   <= 1'b0;
    item_if.payload <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= CFG_FULL_DUTY;
    cfg_if.data     <= '0;

    led_cfg   = default_cfg();
    cur_pat   = PAT_OFF;
    cur_step  = '0;
    pat_ms    = '0;
    fade_ms   = '0;
    blink_cnt = 0;
    fade_lvl  = '0;
    fade_up   = 1'b1;
    duty_q    = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_patterns();
    test_fade_above_full();
    test_default_timing();
    test_short_timing();
    test_low_extremes();
    test_high_extremes();
    test_random_settings();
    drain_led();

    if (mismatch_cnt == 0 && led_status_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- status_led_pattern_sequencer.f -----
design/slps_pkg.sv
design/slps_if.sv
design/slps_cfg_regs.sv
design/slps_engine.sv
design/status_led_pattern_sequencer.sv
verif/tb_top.sv
